// ===== hw/rtl/psnap_pkg.sv =====
// Shared tables, constants and helper functions for the preferred value snap block.
package psnap_pkg;

   // Register map (word index on the configuration port)
   typedef enum logic {
      CSR_SERIES = 1'b0,
      CSR_TOL    = 1'b1
   } csr_index_type;

   localparam logic        SERIES_E24 = 1'b0;
   localparam logic        SERIES_E96 = 1'b1;
   localparam int          E24_COUNT  = 24;
   localparam int          E96_COUNT  = 96;
   localparam logic [19:0] MILLION    = 20'd1000000;
   localparam int          POW_W      = 72;

   localparam logic [9:0] TAB24 [E24_COUNT] = '{
      10'd10, 10'd11, 10'd12, 10'd13, 10'd15, 10'd16, 10'd18, 10'd20, 10'd22, 10'd24,
      10'd27, 10'd30, 10'd33, 10'd36, 10'd39, 10'd43, 10'd47, 10'd51, 10'd56, 10'd62,
      10'd68, 10'd75, 10'd82, 10'd91};

   localparam logic [9:0] TAB96 [E96_COUNT] = '{
      10'd100, 10'd102, 10'd105, 10'd107, 10'd110, 10'd113, 10'd115, 10'd118, 10'd121,
      10'd124, 10'd127, 10'd130, 10'd133, 10'd137, 10'd140, 10'd143, 10'd147, 10'd150,
      10'd154, 10'd158, 10'd162, 10'd165, 10'd169, 10'd174, 10'd178, 10'd182, 10'd187,
      10'd191, 10'd196, 10'd200, 10'd205, 10'd210, 10'd215, 10'd221, 10'd226, 10'd232,
      10'd237, 10'd243, 10'd249, 10'd255, 10'd261, 10'd267, 10'd274, 10'd280, 10'd287,
      10'd294, 10'd301, 10'd309, 10'd316, 10'd324, 10'd332, 10'd340, 10'd348, 10'd357,
      10'd365, 10'd374, 10'd383, 10'd392, 10'd402, 10'd412, 10'd422, 10'd432, 10'd442,
      10'd453, 10'd464, 10'd475, 10'd487, 10'd499, 10'd511, 10'd523, 10'd536, 10'd549,
      10'd562, 10'd576, 10'd590, 10'd604, 10'd619, 10'd634, 10'd649, 10'd665, 10'd681,
      10'd698, 10'd715, 10'd732, 10'd750, 10'd768, 10'd787, 10'd806, 10'd825, 10'd845,
      10'd866, 10'd887, 10'd909, 10'd931, 10'd953, 10'd976};

   // Power of ten, wide enough for every supported decade
   function automatic logic [POW_W-1:0] pow10(input int n);
      logic [POW_W-1:0] r;
      r = POW_W'(1);
      for (int k = 0; k < n; k++) begin
         r = r * POW_W'(10);
      end
      return r;
   endfunction

   // Highest decade a value of vb bits can reach
   function automatic int dec_max(input int vb);
      int c;
      c = 0;
      for (int k = 1; k < 22; k++) begin
         if (pow10(k) < (POW_W'(1) << vb)) begin
            c++;
         end
      end
      return c;
   endfunction

   function automatic int dec_width(input int vb);
      return $clog2(dec_max(vb) + 1);
   endfunction

   // Table entry of the selected series; zero past the end of that series
   function automatic logic [9:0] entry(input logic sel, input int i);
      logic [9:0] r;
      r = 10'd0;
      if (sel == SERIES_E96) begin
         if (i < E96_COUNT) r = TAB96[7'(i)];
      end else begin
         if (i < E24_COUNT) r = TAB24[5'(i)];
      end
      return r;
   endfunction

   // Divide a table entry by ten or by a hundred (reciprocal multiply, exact below 1000)
   function automatic logic [9:0] div10(input logic [9:0] x);
      logic [19:0] p;
      p = 20'(x) * 20'd205;
      return 10'(p >> 11);
   endfunction

   function automatic logic [9:0] div100(input logic [9:0] x);
      logic [19:0] p;
      p = 20'(x) * 20'd41;
      return 10'(p >> 12);
   endfunction

endpackage

// ===== hw/rtl/psnap_csr.sv =====
// Configuration registers behind the APB-style port.
module psnap_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic        series_sel,
   output logic [19:0] tol_ppm
);
   import psnap_pkg::*;

   logic          series_ff, series_in;
   logic [19:0]   tol_ff, tol_in;
   logic          wr_en;
   csr_index_type idx;

   assign pready = 1'b1;
   assign idx    = csr_index_type'(paddr[2]);
   assign wr_en  = psel & penable & pwrite & pready;

   // Update the addressed register on a write access
   always_comb begin
      series_in = series_ff;
      tol_in    = tol_ff;
      if (wr_en) begin
         case (idx)
            CSR_SERIES: series_in = pwdata[0];
            CSR_TOL:    tol_in    = pwdata[19:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff <= 1'b0;
         tol_ff    <= 20'd0;
      end else begin
         series_ff <= series_in;
         tol_ff    <= tol_in;
      end
   end

   // Return the addressed register
   always_comb begin
      case (idx)
         CSR_SERIES: prdata = {31'd0, series_ff};
         CSR_TOL:    prdata = {12'd0, tol_ff};
         default:    prdata = 32'd0;
      endcase
   end

   assign series_sel = series_ff;
   assign tol_ppm    = tol_ff;
endmodule

// ===== hw/rtl/psnap_match.sv =====
// Decade detect, midpoint compare against the series table and index encode.
module psnap_match #(
   parameter int VALUE_BITS = 40
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   input  logic [VALUE_BITS-1:0]                            in_value,
   input  logic                                             series_sel,
   output logic                                             out_valid,
   output logic                                             out_zero,
   output logic                                             out_sel,
   output logic [psnap_pkg::dec_width(VALUE_BITS)-1:0]      out_decade,
   output logic [VALUE_BITS+6:0]                            out_scaled,
   output logic [6:0]                                       out_index,
   output logic [9:0]                                       out_entry
);
   import psnap_pkg::*;

   localparam int DMAX  = dec_max(VALUE_BITS);
   localparam int DW    = dec_width(VALUE_BITS);
   localparam int W_W   = VALUE_BITS + 7;
   localparam int CMP_W = VALUE_BITS + 11;
   localparam int NPAIR = E96_COUNT - 1;

   // Stage 1: captured input
   logic                  s1_vld_ff, s1_vld_in;
   logic [VALUE_BITS-1:0] s1_val_ff, s1_val_in;
   logic                  s1_sel_ff, s1_sel_in;
   // Stage 2: decade and scaled value
   logic                  s2_vld_ff, s2_vld_in;
   logic [DW-1:0]         s2_dec_ff, s2_dec_in;
   logic [W_W-1:0]        s2_w_ff, s2_w_in;
   logic                  s2_zero_ff, s2_zero_in;
   logic                  s2_sel_ff, s2_sel_in;
   // Stage 3: midpoint compare vector
   logic                  s3_vld_ff, s3_vld_in;
   logic [NPAIR-1:0]      s3_th_ff, s3_th_in;
   logic [DW-1:0]         s3_dec_ff;
   logic [W_W-1:0]        s3_w_ff;
   logic                  s3_zero_ff;
   logic                  s3_sel_ff;
   // Output stage
   logic                  o_vld_ff, o_vld_in;
   logic [6:0]            o_idx_ff, o_idx_in;
   logic [9:0]            o_ent_ff, o_ent_in;
   logic [DW-1:0]         o_dec_ff;
   logic [W_W-1:0]        o_w_ff;
   logic                  o_zero_ff;
   logic                  o_sel_ff;

   assign s1_vld_in = in_valid;
   assign s1_val_in = in_value;
   assign s1_sel_in = series_sel;

   // Count the powers of ten not above the value; scale by ten or a hundred
   always_comb begin
      s2_dec_in = '0;
      for (int k = 1; k <= DMAX; k++) begin
         if (s1_val_ff >= VALUE_BITS'(pow10(k))) begin
            s2_dec_in = s2_dec_in + DW'(1);
         end
      end
      if (s1_sel_ff == SERIES_E96) begin
         s2_w_in = (W_W'(s1_val_ff) << 6) + (W_W'(s1_val_ff) << 5) + (W_W'(s1_val_ff) << 2);
      end else begin
         s2_w_in = (W_W'(s1_val_ff) << 3) + (W_W'(s1_val_ff) << 1);
      end
      s2_zero_in = (s1_val_ff == '0);
      s2_vld_in  = s1_vld_ff;
      s2_sel_in  = s1_sel_ff;
   end

   // Flag each neighbor pair whose midpoint lies strictly below the value
   always_comb begin
      logic [CMP_W-1:0] thr;
      logic [CMP_W-1:0] w2;
      logic             used;
      w2 = CMP_W'(s2_w_ff) << 1;
      for (int i = 0; i < NPAIR; i++) begin
         thr  = '0;
         used = (s2_sel_ff == SERIES_E96) || (i < E24_COUNT - 1);
         for (int dd = 0; dd <= DMAX; dd++) begin
            if (s2_dec_ff == DW'(dd)) begin
               thr = CMP_W'((POW_W'(entry(s2_sel_ff, i)) + POW_W'(entry(s2_sel_ff, i + 1)))
                            * pow10(dd));
            end
         end
         s3_th_in[i] = used && (w2 > thr);
      end
      s3_vld_in = s2_vld_ff;
   end

   // Encode the thermometer edge into the table index
   always_comb begin
      logic nxt;
      o_idx_in = 7'd0;
      for (int i = 0; i < NPAIR; i++) begin
         nxt = (i < NPAIR - 1) ? s3_th_ff[(i < NPAIR - 1) ? i + 1 : i] : 1'b0;
         if (s3_th_ff[i] && !nxt) begin
            o_idx_in = o_idx_in | 7'(i + 1);
         end
      end
      o_ent_in = entry(s3_sel_ff, int'(o_idx_in));
      o_vld_in = s3_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
         o_vld_ff  <= o_vld_in;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      s1_val_ff  <= s1_val_in;
      s1_sel_ff  <= s1_sel_in;
      s2_dec_ff  <= s2_dec_in;
      s2_w_ff    <= s2_w_in;
      s2_zero_ff <= s2_zero_in;
      s2_sel_ff  <= s2_sel_in;
      s3_th_ff   <= s3_th_in;
      s3_dec_ff  <= s2_dec_ff;
      s3_w_ff    <= s2_w_ff;
      s3_zero_ff <= s2_zero_ff;
      s3_sel_ff  <= s2_sel_ff;
      o_idx_ff   <= o_idx_in;
      o_ent_ff   <= o_ent_in;
      o_dec_ff   <= s3_dec_ff;
      o_w_ff     <= s3_w_ff;
      o_zero_ff  <= s3_zero_ff;
      o_sel_ff   <= s3_sel_ff;
   end

   assign out_valid  = o_vld_ff;
   assign out_zero   = o_zero_ff;
   assign out_sel    = o_sel_ff;
   assign out_decade = o_dec_ff;
   assign out_scaled = o_w_ff;
   assign out_index  = o_idx_ff;
   assign out_entry  = o_ent_ff;
endmodule

// ===== hw/rtl/psnap_measure.sv =====
// Snapped value, distance and tolerance check for the chosen entry.
module psnap_measure #(
   parameter int VALUE_BITS = 40
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   input  logic                                        in_zero,
   input  logic                                        in_sel,
   input  logic [psnap_pkg::dec_width(VALUE_BITS)-1:0] in_decade,
   input  logic [VALUE_BITS+6:0]                       in_scaled,
   input  logic [6:0]                                  in_index,
   input  logic [9:0]                                  in_entry,
   input  logic [19:0]                                 tol_ppm,
   output logic                                        rsp_valid,
   output logic [40:0]                                 rsp_snapped_value,
   output logic [9:0]                                  rsp_mantissa_code,
   output logic [6:0]                                  rsp_table_index,
   output logic [3:0]                                  rsp_decade,
   output logic                                        rsp_in_tolerance
);
   import psnap_pkg::*;

   localparam int DMAX = dec_max(VALUE_BITS);
   localparam int DW   = dec_width(VALUE_BITS);
   localparam int W_W  = VALUE_BITS + 7;
   localparam int E_W  = VALUE_BITS + 10;
   localparam int LR_W = VALUE_BITS + 30;

   // Common payload carried alongside
   logic          m1_vld_ff, m2_vld_ff, m3_vld_ff, m4_vld_ff, m5_vld_ff, o_vld_ff;
   logic          m1_zero_ff, m2_zero_ff, m3_zero_ff, m4_zero_ff, m5_zero_ff;
   logic [DW-1:0] m1_dec_ff, m2_dec_ff, m3_dec_ff, m4_dec_ff, m5_dec_ff;
   logic [6:0]    m1_idx_ff, m2_idx_ff, m3_idx_ff, m4_idx_ff, m5_idx_ff;
   logic [9:0]    m1_ent_ff, m2_ent_ff, m3_ent_ff, m4_ent_ff, m5_ent_ff;
   logic [W_W-1:0] m1_w_ff, m2_w_ff;
   logic [E_W-1:0] m3_snap_ff, m4_snap_ff, m5_snap_ff;
   logic [W_W-1:0] m3_w_ff;
   // Stage 1: partial products of entry and powers of ten
   logic [41:0]   m1_pl_ff, m1_pl_in, m1_ph_ff, m1_ph_in;
   logic [41:0]   m1_ql_ff, m1_ql_in, m1_qh_ff, m1_qh_in;
   logic [9:0]    m1_small_ff, m1_small_in;
   logic          m1_fine_ff, m1_fine_in;
   // Stage 2: entry value in scaled units and snapped value
   logic [E_W-1:0] m2_e_ff, m2_e_in;
   logic [E_W-1:0] m2_snap_ff, m2_snap_in;
   // Stage 3: distance
   logic [E_W-1:0] m3_d_ff, m3_d_in;
   // Stage 4: partial products for the tolerance compare
   logic [55:0]   m4_dl_ff, m4_dl_in, m4_dh_ff, m4_dh_in;
   logic [55:0]   m4_wl_ff, m4_wl_in, m4_wh_ff, m4_wh_in;
   // Stage 5: both sides of the compare
   logic [LR_W-1:0] m5_l_ff, m5_l_in, m5_r_ff, m5_r_in;
   // Output registers
   logic [40:0]   o_snap_ff, o_snap_in;
   logic [9:0]    o_ent_ff, o_ent_in;
   logic [6:0]    o_idx_ff, o_idx_in;
   logic [3:0]    o_dec_ff, o_dec_in;
   logic          o_ok_ff, o_ok_in;

   // Select 10^d and 10^(d-k), split them and multiply by the entry
   always_comb begin
      logic [63:0] p;
      logic [63:0] q;
      p = '0;
      q = '0;
      m1_fine_in = (in_sel == SERIES_E96) ? (in_decade >= DW'(2)) : (in_decade >= DW'(1));
      for (int dd = 0; dd <= DMAX; dd++) begin
         if (in_decade == DW'(dd)) begin
            p = 64'(pow10(dd));
            if (dd >= 2 && in_sel == SERIES_E96) q = 64'(pow10((dd >= 2) ? dd - 2 : 0));
            if (dd >= 1 && in_sel == SERIES_E24) q = 64'(pow10((dd >= 1) ? dd - 1 : 0));
         end
      end
      m1_pl_in = 42'(in_entry) * 42'(p[31:0]);
      m1_ph_in = 42'(in_entry) * 42'(p[63:32]);
      m1_ql_in = 42'(in_entry) * 42'(q[31:0]);
      m1_qh_in = 42'(in_entry) * 42'(q[63:32]);
      m1_small_in = (in_sel == SERIES_E96 && in_decade == DW'(0)) ? div100(in_entry)
                                                                   : div10(in_entry);
   end

   // Join the partial products
   always_comb begin
      m2_e_in = E_W'((74'(m1_ph_ff) << 32) + 74'(m1_pl_ff));
      if (m1_fine_ff) begin
         m2_snap_in = E_W'((74'(m1_qh_ff) << 32) + 74'(m1_ql_ff));
      end else begin
         m2_snap_in = E_W'(m1_small_ff);
      end
   end

   // Absolute distance in scaled units
   always_comb begin
      if (E_W'(m2_w_ff) > m2_e_ff) begin
         m3_d_in = E_W'(m2_w_ff) - m2_e_ff;
      end else begin
         m3_d_in = m2_e_ff - E_W'(m2_w_ff);
      end
   end

   // Split distance and scaled value into 36-bit halves for the products
   always_comb begin
      logic [71:0] dx;
      logic [71:0] wx;
      dx = 72'(m3_d_ff);
      wx = 72'(m3_w_ff);
      m4_dl_in = 56'(dx[35:0]) * 56'(MILLION);
      m4_dh_in = 56'(dx[71:36]) * 56'(MILLION);
      m4_wl_in = 56'(wx[35:0]) * 56'(tol_ppm);
      m4_wh_in = 56'(wx[71:36]) * 56'(tol_ppm);
   end

   assign m5_l_in = LR_W'((92'(m4_dh_ff) << 36) + 92'(m4_dl_ff));
   assign m5_r_in = LR_W'((92'(m4_wh_ff) << 36) + 92'(m4_wl_ff));

   // Compare and drop everything for a zero value
   always_comb begin
      if (m5_zero_ff) begin
         o_snap_in = '0;
         o_ent_in  = '0;
         o_idx_in  = '0;
         o_dec_in  = '0;
         o_ok_in   = 1'b0;
      end else begin
         o_snap_in = 41'(m5_snap_ff);
         o_ent_in  = m5_ent_ff;
         o_idx_in  = m5_idx_ff;
         o_dec_in  = 4'(m5_dec_ff);
         o_ok_in   = (m5_l_ff <= m5_r_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
         m4_vld_ff <= 1'b0;
         m5_vld_ff <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else begin
         m1_vld_ff <= in_valid;
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
         m4_vld_ff <= m3_vld_ff;
         m5_vld_ff <= m4_vld_ff;
         o_vld_ff  <= m5_vld_ff;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      m1_zero_ff  <= in_zero;
      m1_dec_ff   <= in_decade;
      m1_idx_ff   <= in_index;
      m1_ent_ff   <= in_entry;
      m1_w_ff     <= in_scaled;
      m1_pl_ff    <= m1_pl_in;
      m1_ph_ff    <= m1_ph_in;
      m1_ql_ff    <= m1_ql_in;
      m1_qh_ff    <= m1_qh_in;
      m1_small_ff <= m1_small_in;
      m1_fine_ff  <= m1_fine_in;

      m2_zero_ff  <= m1_zero_ff;
      m2_dec_ff   <= m1_dec_ff;
      m2_idx_ff   <= m1_idx_ff;
      m2_ent_ff   <= m1_ent_ff;
      m2_w_ff     <= m1_w_ff;
      m2_e_ff     <= m2_e_in;
      m2_snap_ff  <= m2_snap_in;

      m3_zero_ff  <= m2_zero_ff;
      m3_dec_ff   <= m2_dec_ff;
      m3_idx_ff   <= m2_idx_ff;
      m3_ent_ff   <= m2_ent_ff;
      m3_w_ff     <= m2_w_ff;
      m3_snap_ff  <= m2_snap_ff;
      m3_d_ff     <= m3_d_in;

      m4_zero_ff  <= m3_zero_ff;
      m4_dec_ff   <= m3_dec_ff;
      m4_idx_ff   <= m3_idx_ff;
      m4_ent_ff   <= m3_ent_ff;
      m4_snap_ff  <= m3_snap_ff;
      m4_dl_ff    <= m4_dl_in;
      m4_dh_ff    <= m4_dh_in;
      m4_wl_ff    <= m4_wl_in;
      m4_wh_ff    <= m4_wh_in;

      m5_zero_ff  <= m4_zero_ff;
      m5_dec_ff   <= m4_dec_ff;
      m5_idx_ff   <= m4_idx_ff;
      m5_ent_ff   <= m4_ent_ff;
      m5_snap_ff  <= m4_snap_ff;
      m5_l_ff     <= m5_l_in;
      m5_r_ff     <= m5_r_in;

      o_snap_ff   <= o_snap_in;
      o_ent_ff    <= o_ent_in;
      o_idx_ff    <= o_idx_in;
      o_dec_ff    <= o_dec_in;
      o_ok_ff     <= o_ok_in;
   end

   assign rsp_valid         = o_vld_ff;
   assign rsp_snapped_value = o_snap_ff;
   assign rsp_mantissa_code = o_ent_ff;
   assign rsp_table_index   = o_idx_ff;
   assign rsp_decade        = o_dec_ff;
   assign rsp_in_tolerance  = o_ok_ff;
endmodule

// ===== hw/rtl/preferred_value_snap_top.sv =====
// Top level of the preferred value snap block: configuration port and two pipeline halves.
//
// Snaps a positive value to the nearest E24 or E96 preferred value of its own decade
// (ties go to the lower entry) and flags whether the relative error is within the
// tolerance register. The block takes one transaction every cycle: busy never rises, and
// start alone accepts a value. rsp_valid marks one result per transaction, in order, once
// it has passed the match and measure register stages; it is high for a single cycle
// only, since the receiver cannot stall. The depth is set by the decade detect,
// the midpoint compare, the index encode and the split wide multiplies of the
// tolerance check, each in its own register stage. Write series_select and
// the tolerance register only while no transaction is in flight.
module preferred_value_snap_top #(
   parameter int VALUE_BITS = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output logic                  rsp_valid,
   output logic [40:0]           rsp_snapped_value,
   output logic [9:0]            rsp_mantissa_code,
   output logic [6:0]            rsp_table_index,
   output logic [3:0]            rsp_decade,
   output logic                  rsp_in_tolerance
);
   import psnap_pkg::*;

   localparam int DW = dec_width(VALUE_BITS);

   logic                  series_sel;
   logic [19:0]           tol_ppm;
   logic                  mt_valid;
   logic                  mt_zero;
   logic                  mt_sel;
   logic [DW-1:0]         mt_decade;
   logic [VALUE_BITS+6:0] mt_scaled;
   logic [6:0]            mt_index;
   logic [9:0]            mt_entry;

   // The pipeline never stalls
   assign busy = 1'b0;

   psnap_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .series_sel (series_sel),
      .tol_ppm    (tol_ppm)
   );

   psnap_match #(.VALUE_BITS(VALUE_BITS)) u_match (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start & ~busy),
      .in_value   (req_value),
      .series_sel (series_sel),
      .out_valid  (mt_valid),
      .out_zero   (mt_zero),
      .out_sel    (mt_sel),
      .out_decade (mt_decade),
      .out_scaled (mt_scaled),
      .out_index  (mt_index),
      .out_entry  (mt_entry)
   );

   psnap_measure #(.VALUE_BITS(VALUE_BITS)) u_measure (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (mt_valid),
      .in_zero           (mt_zero),
      .in_sel            (mt_sel),
      .in_decade         (mt_decade),
      .in_scaled         (mt_scaled),
      .in_index          (mt_index),
      .in_entry          (mt_entry),
      .tol_ppm           (tol_ppm),
      .rsp_valid         (rsp_valid),
      .rsp_snapped_value (rsp_snapped_value),
      .rsp_mantissa_code (rsp_mantissa_code),
      .rsp_table_index   (rsp_table_index),
      .rsp_decade        (rsp_decade),
      .rsp_in_tolerance  (rsp_in_tolerance)
   );
endmodule

// ===== bench/tb_preferred_value_snap_top.sv =====
// Testbench for the preferred value snap block: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

module tb_preferred_value_snap_top;
   import psnap_pkg::*;

   localparam int VB = 40;

   typedef struct packed {
      logic [40:0] snapped;
      logic [9:0]  mantissa;
      logic [6:0]  index;
      logic [3:0]  decade;
      logic        in_tol;
   } snap_result_type;

   // Predict snapped values and match them against the block's transactions
   class snap_scoreboard_type;
      logic        series;
      logic [19:0] tol_ppm;
      snap_result_type expected_q[$];
      int          errors;

      function new();
         series  = SERIES_E24;
         tol_ppm = '0;
         errors  = 0;
      endfunction

      // Work out the snapped result of one accepted value
      function void note_value(logic [VB-1:0] v);
         snap_result_type r;
         logic [63:0]  p, pk, scale, diff, min_dist, e, lhs_b;
         logic [127:0] lhs, rhs;
         int           d, k, count, best;
         logic         fine;
         r = '0;
         if (v != 0) begin
            if (series == SERIES_E96) begin
               count = E96_COUNT; k = 2; scale = 100;
            end else begin
               count = E24_COUNT; k = 1; scale = 10;
            end
            p = 1; d = 0;
            while (64'(v) / 10 >= p) begin
               p = p * 10; d++;
            end
            fine = d >= k;
            pk = 1;
            if (fine) repeat (d - k) pk = pk * 10;
            best = 0; min_dist = 0;
            for (int i = 0; i < count; i++) begin
               e = (series == SERIES_E96) ? 64'(TAB96[i]) : 64'(TAB24[i]);
               lhs_b = fine ? 64'(v) : 64'(v) * scale;
               e = fine ? e * pk : e * p;
               diff = (lhs_b > e) ? lhs_b - e : e - lhs_b;
               if (i == 0 || diff < min_dist) begin
                  min_dist = diff; best = i;
               end
            end
            e = (series == SERIES_E96) ? 64'(TAB96[best]) : 64'(TAB24[best]);
            lhs = 128'(min_dist) * 128'd1000000;
            if (fine) begin
               r.snapped = 41'(e * pk);
               rhs = 128'(tol_ppm) * 128'(v);
            end else begin
               r.snapped = 41'((e * p) / scale);
               rhs = 128'(tol_ppm) * 128'(v) * 128'(scale);
            end
            r.mantissa = 10'(e);
            r.index    = 7'(best);
            r.decade   = 4'(d);
            r.in_tol   = lhs <= rhs;
         end
         expected_q.push_back(r);
      endfunction

      // Compare one result transaction with the oldest prediction
      function void check_result(snap_result_type got);
         snap_result_type x;
         if (expected_q.size() == 0) begin
            $error("unexpected result transaction snapped=%0d", got.snapped);
            errors++;
            return;
         end
         x = expected_q.pop_front();
         if (got.snapped != x.snapped) begin
            $error("snapped_value expected %0d actual %0d", x.snapped, got.snapped);
            errors++;
         end
         if (got.mantissa != x.mantissa) begin
            $error("mantissa_code expected %0d actual %0d", x.mantissa, got.mantissa);
            errors++;
         end
         if (got.index != x.index) begin
            $error("table_index expected %0d actual %0d", x.index, got.index);
            errors++;
         end
         if (got.decade != x.decade) begin
            $error("decade expected %0d actual %0d", x.decade, got.decade);
            errors++;
         end
         if (got.in_tol != x.in_tol) begin
            $error("in_tolerance expected %0d actual %0d", x.in_tol, got.in_tol);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [VB-1:0]     req_value;
   logic              psel, penable, pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata, prdata;
   logic              pready;
   logic              rsp_valid;
   logic [40:0]       rsp_snapped_value;
   logic [9:0]        rsp_mantissa_code;
   logic [6:0]        rsp_table_index;
   logic [3:0]        rsp_decade;
   logic              rsp_in_tolerance;

   snap_scoreboard_type sb = new();
   int             sender_idle_pct;

   preferred_value_snap_top #(.VALUE_BITS(VB)) dut (.*);

   always #5 clock = ~clock;

   // Sample result transactions
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result({rsp_snapped_value, rsp_mantissa_code, rsp_table_index,
                          rsp_decade, rsp_in_tolerance});
   end

   // Hard stop for a hung block
   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

   // Offer one value after any idle cycles and hold it until accepted
   task automatic send_value(logic [VB-1:0] v);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy);
      sb.note_value(v);
   endtask

   // Hold off until every expected result is back and the pipe is empty
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Write one register through setup and access phases
   task automatic csr_write(csr_index_type idx, logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == CSR_SERIES) sb.series = data[0];
      else sb.tol_ppm = data[19:0];
      @(posedge clock);
   endtask

   task automatic configure(logic ser, logic [19:0] tol);
      drain();
      csr_write(CSR_SERIES, {31'd0, ser});
      csr_write(CSR_TOL, {12'd0, tol});
   endtask

   // Random value: full range, near a table entry, neighbor midpoints, or small
   function automatic logic [VB-1:0] random_value();
      logic [63:0] pk, e, v;
      int d, i, k, n;
      k = (sb.series == SERIES_E96) ? 2 : 1;
      n = (sb.series == SERIES_E96) ? E96_COUNT : E24_COUNT;
      d = $urandom_range(12, k);
      pk = 1;
      repeat (d - k) pk = pk * 10;
      i = $urandom_range(n - 1);
      e = (sb.series == SERIES_E96) ? 64'(TAB96[i]) : 64'(TAB24[i]);
      case ($urandom_range(3))
         0: v = {$urandom, $urandom};
         1: v = e * pk + 64'($urandom_range(6)) - 3;
         2: begin
            // midpoint between neighbors, tie goes low
            if (i == n - 1) i = n - 2;
            e = (sb.series == SERIES_E96) ? 64'(TAB96[i]) + 64'(TAB96[i + 1])
                                          : 64'(TAB24[i]) + 64'(TAB24[i + 1]);
            v = (e * pk) / 2;
         end
         default: v = $urandom_range(1200);
      endcase
      return VB'(v);
   endfunction

   task automatic directed_values();
      logic [63:0] vals[$] = '{0, 1, 9, 10, 11, 95, 99, 100, 105, 955, 999, 1000,
                               9999, 9550, 64'd999999999999, 64'd1000000000000,
                               64'hFF_FFFF_FFFF, 64'hAA_AAAA_AAAA, 64'h55_5555_5555};
      foreach (vals[i]) send_value(VB'(vals[i]));
   endtask

   initial begin
      logic [19:0] tol_set[6];
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      sender_idle_pct = 32;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners on both series, with zero tolerance and with one million ppm
      configure(SERIES_E24, 20'd0);
      directed_values();
      configure(SERIES_E96, 20'd1000000);
      directed_values();

      tol_set = '{20'd0, 20'hFFFFF, 20'd1000000, 20'd0, 20'd0, 20'd0};
      for (int b = 0; b < 6; b++) begin
         if (b >= 3) tol_set[b] = (b == 3) ? 20'($urandom_range(50000))
                                           : 20'($urandom_range(1048575));
         configure(logic'(b % 2), tol_set[b]);
         sender_idle_pct = (b < 2) ? 32 : (b < 4) ? 81 : 0;
         for (int n = 0; n < 300; n++) begin
            if (b == 2 && n == 150) drain();
            send_value(random_value());
         end
      end

      drain();
      if (sb.expected_q.size() == 0 && sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
